// ===== hdl/llrm_pkg.sv =====
package llrm_pkg;

    localparam int THREAD_SLOTS = 8;
    localparam int LINE_BYTES   = 128;
    localparam int SLOT_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int MASK_BITS    = 8;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_RESERVE = 2'd0;
    localparam logic [1:0] KIND_ACQUIRE = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;

    localparam logic RES_NOTICE  = 1'b0;
    localparam logic RES_CLOSING = 1'b1;

    typedef enum logic [1:0] {
        OP_RESERVE,
        OP_ACQUIRE,
        OP_WRITE,
        OP_NONE
    } t_op;

    typedef enum logic [0:0] {
        B_IDLE,
        B_EMIT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  thread_slot;
        logic [31:0] address;
        logic [7:0]  changed_mask;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] lost_slot;
        logic       acquired;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_op                       op;
        logic                      slot_ok;
        logic [SLOT_W-1:0]         slot;
        logic [31:0]               address;
        logic [MASK_BITS-1:0]      changed_mask;
    } t_cmd;

endpackage

// ===== hdl/llrm_front.sv =====
module llrm_front
    import llrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_busy,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_busy = r_valid && i_q_full;
    assign o_push = r_valid && !i_q_full;
    assign accept = i_start && !o_busy;
    assign o_cmd  = r_cmd;

    // Decode the item kind and check the slot range.
    always_comb begin
        n_cmd              = r_cmd;
        n_valid            = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid            = 1'b1;
            n_cmd.slot_ok      = (32'(i_item.thread_slot) < THREAD_SLOTS);
            n_cmd.slot         = SLOT_W'(i_item.thread_slot);
            n_cmd.address      = i_item.address;
            n_cmd.changed_mask = MASK_BITS'(i_item.changed_mask);
            case (i_item.kind)
                KIND_RESERVE: n_cmd.op = OP_RESERVE;
                KIND_ACQUIRE: n_cmd.op = OP_ACQUIRE;
                KIND_WRITE:   n_cmd.op = OP_WRITE;
                default:      n_cmd.op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// ===== hdl/llrm_queue.sv =====
module llrm_queue
    import llrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wptr;
    logic [QPTR_W-1:0] n_rptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_push |-> !o_full)
        else $error("queue written while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== hdl/llrm_back.sv =====
module llrm_back
    import llrm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_back_state             r_state;
    t_back_state             n_state;
    logic [THREAD_SLOTS-1:0] r_entry_valid;
    logic [THREAD_SLOTS-1:0] n_entry_valid;
    logic [31:0]             r_entry_address [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0] r_pending;
    logic [THREAD_SLOTS-1:0] n_pending;
    logic                    r_acq;
    logic                    n_acq;
    logic                    r_strobe;
    logic                    n_strobe;
    t_out_item               r_result;
    t_out_item               n_result;

    logic                    exec;
    logic                    emit_close;
    logic                    emit_note;
    logic                    own_valid;
    logic                    own_match;
    logic                    addr_wr;
    logic [THREAD_SLOTS-1:0] hits;
    logic [SLOT_W-1:0]       first;
    logic [31:0]             diff;
    logic                    mask_bit;

    assign emit_close = (r_state == B_EMIT) && (r_pending == '0);
    assign emit_note  = (r_state == B_EMIT) && (r_pending != '0);
    assign exec       = !i_q_empty && ((r_state == B_IDLE) || emit_close);
    assign o_pop      = exec;
    assign own_valid  = i_cmd.slot_ok && r_entry_valid[i_cmd.slot];
    assign own_match  = (r_entry_address[i_cmd.slot] == i_cmd.address);
    assign o_strobe   = r_strobe;
    assign o_result   = r_result;

    // Lowest pending slot goes out first.
    always_comb begin
        first = '0;
        for (int s = THREAD_SLOTS - 1; s >= 0; s--) begin
            if (r_pending[s]) begin
                first = SLOT_W'(s);
            end
        end
    end

    // Match all slots in parallel against the item at the queue head.
    always_comb begin
        hits          = '0;
        n_entry_valid = r_entry_valid;
        n_acq         = r_acq;
        addr_wr       = 1'b0;
        diff          = '0;
        mask_bit      = 1'b0;
        case (i_cmd.op)
            OP_RESERVE: begin
                if (i_cmd.slot_ok) begin
                    n_entry_valid[i_cmd.slot] = 1'b1;
                    addr_wr                   = 1'b1;
                end
                n_acq = 1'b0;
            end
            OP_ACQUIRE: begin
                n_acq = 1'b0;
                if (own_valid) begin
                    n_entry_valid[i_cmd.slot] = 1'b0;
                    if (own_match) begin
                        n_acq = 1'b1;
                        for (int s = 0; s < THREAD_SLOTS; s++) begin
                            if (r_entry_valid[s] && (SLOT_W'(s) != i_cmd.slot)
                                && (r_entry_address[s] == i_cmd.address)) begin
                                hits[s] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_WRITE: begin
                n_acq = 1'b0;
                for (int s = 0; s < THREAD_SLOTS; s++) begin
                    diff     = i_cmd.address - r_entry_address[s];
                    mask_bit = (s < MASK_BITS) ? i_cmd.changed_mask[s % MASK_BITS] : 1'b0;
                    if (r_entry_valid[s] && mask_bit && (diff < 32'(LINE_BYTES))) begin
                        hits[s] = 1'b1;
                    end
                end
            end
            default: begin
                n_acq = 1'b0;
            end
        endcase
        n_entry_valid = n_entry_valid & ~hits;
    end

    // Sequencer: notices one per cycle, then the closing result.
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_strobe  = 1'b0;
        n_result  = '0;
        if (emit_note) begin
            n_strobe             = 1'b1;
            n_result.result_kind = RES_NOTICE;
            n_result.lost_slot   = 3'(first);
            n_pending[first]     = 1'b0;
        end else if (emit_close) begin
            n_strobe             = 1'b1;
            n_result.result_kind = RES_CLOSING;
            n_result.acquired    = r_acq;
            n_result.last        = 1'b1;
            n_state              = B_IDLE;
        end
        if (exec) begin
            n_state   = B_EMIT;
            n_pending = hits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_entry_valid <= '0;
            r_pending     <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_strobe  <= n_strobe;
            if (exec) begin
                r_entry_valid <= n_entry_valid;
            end
        end
        r_result <= n_result;
        if (exec) begin
            r_acq <= n_acq;
        end
        if (exec && addr_wr) begin
            r_entry_address[i_cmd.slot] <= i_cmd.address;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (r_pending == '0))
        else $error("notices left pending while idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.result_kind == RES_NOTICE))
        |-> (!o_result.last && !o_result.acquired))
        else $error("notice carries closing fields");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (i_cmd.op == OP_ACQUIRE) && i_cmd.slot_ok)
        |=> !r_entry_valid[$past(i_cmd.slot)])
        else $error("acquire left its own reservation in place");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (hits != '0)) |=> ((r_pending & r_entry_valid) == '0))
        else $error("reported slot still holds its reservation");

endmodule

// ===== hdl/lock_line_reservation_monitor_core.sv =====
// Lock-line reservation monitor.
//
// Input channel: present an item on i_item and raise i_start; the transfer
// happens at a rising edge where i_start is high and o_busy is low. Items are
// reserve (record a line reservation for a thread slot), acquire (conditional
// store: succeeds only if the slot holds a reservation at that exact address)
// and memory write (breaks every changed reservation whose line covers it).
// Result channel: each result is on o_result for exactly one cycle while
// o_strobe is high. An item yields zero or more lost notices in ascending
// slot order, then one closing result with last set.
// Path: the front end registers each transfer, the command queue holds it
// until the back end is free, the back end matches all slots in parallel
// and the result register drives o_result. An item's results go out one per
// cycle; a two-entry command queue lets the input side keep accepting while
// notices drain, and o_busy rises only when it is full.
// The receiver cannot stall, so results are never held back.
// Reset (synchronous, active low) clears all reservations, empties the
// queue and drops any result in flight; no clearing pass is needed.
module lock_line_reservation_monitor_core
    import llrm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    // Commands handed from the decoder to the queue.
    t_cmd front_cmd;
    logic front_push;
    // Queue status and the command waiting at its head.
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Front end: registers and decodes each transfer.
    llrm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_busy   (o_busy),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    // Short queue so the front end keeps taking items while notices drain.
    llrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // Back end: owns the reservation table and sequences the results.
    llrm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

// ===== test/lock_line_reservation_monitor_core_tb.sv =====
`timescale 1ns / 100ps

module lock_line_reservation_monitor_core_tb;
    import llrm_pkg::*;

    // Kind code that the block does not define; it must only close.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         IN_W        = $bits(t_in_item);

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_item  i_item = '0;
    logic      o_busy;
    logic      o_strobe;
    t_out_item o_result;

    // Our own copy of the reservation table, updated at each accepted transfer.
    logic        resv_valid [THREAD_SLOTS];
    logic [31:0] resv_addr  [THREAD_SLOTS];

    // Results still owed by the block, oldest first.
    t_out_item pending_results[$];
    t_out_item due_result;
    int        mismatch_count = 0;

    // The sender inserts random idle bursts only while this is set.
    bit        sender_gaps = 1'b1;

    lock_line_reservation_monitor_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    function automatic t_in_item make_item(input logic [1:0] kind, input int slot,
                                           input logic [31:0] addr, input logic [7:0] mask);
        t_in_item it;
        it.kind         = kind;
        it.thread_slot  = slot[2:0];
        it.address      = addr;
        it.changed_mask = mask;
        return it;
    endfunction

    // Line bases lean toward both ends of the address space so that the
    // wrapping coverage check gets exercised.
    function automatic logic [31:0] random_base();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 64));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 64));
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_result(input logic kind, input int slot, input logic acq,
                                        input logic fin);
        t_out_item r;
        r.result_kind = kind;
        r.lost_slot   = slot[2:0];
        r.acquired    = acq;
        r.last        = fin;
        pending_results = {pending_results, r};
    endfunction

    // Applies one accepted transfer to the table copy and queues the
    // notices it causes in ascending slot order, then the closing status.
    function automatic void predict_reservations(input t_in_item it);
        int          s;
        logic        won;
        logic [31:0] offset;
        s   = int'(it.thread_slot);
        won = 1'b0;
        case (it.kind)
            KIND_RESERVE: begin
                if (s < THREAD_SLOTS) begin
                    resv_valid[s] = 1'b1;
                    resv_addr[s]  = it.address;
                end
            end
            KIND_ACQUIRE: begin
                if (s < THREAD_SLOTS && resv_valid[s]) begin
                    resv_valid[s] = 1'b0;
                    if (resv_addr[s] == it.address) begin
                        won = 1'b1;
                        for (int k = 0; k < THREAD_SLOTS; k++) begin
                            if (resv_valid[k] && resv_addr[k] == it.address) begin
                                resv_valid[k] = 1'b0;
                                push_result(RES_NOTICE, k, 1'b0, 1'b0);
                            end
                        end
                    end
                end
            end
            KIND_WRITE: begin
                for (int k = 0; k < THREAD_SLOTS && k < MASK_BITS; k++) begin
                    offset = it.address - resv_addr[k];
                    if (resv_valid[k] && it.changed_mask[k] && offset < LINE_BYTES) begin
                        resv_valid[k] = 1'b0;
                        push_result(RES_NOTICE, k, 1'b0, 1'b0);
                    end
                end
            end
            default: ;
        endcase
        push_result(RES_CLOSING, 0, won, 1'b1);
    endfunction

    // Presents one item and holds it until the transfer happens. The start
    // line is only lowered here when an idle burst follows, so a valid that
    // stays high across back-to-back items never gets two updates in a step.
    task automatic send_item(input t_in_item it);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            i_item  <= IN_W'({$urandom(), $urandom()});
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_reservations(it);
    endtask

    // The sender holds off until every owed result has come out, then
    // leaves a few cycles for the back end to settle.
    task automatic wait_results_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Each strobed result is taken at the edge that ends its cycle and
    // compared field by field with the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", int'(o_result.result_kind), -1);
            end else begin
                due_result = pending_results.pop_front();
                if (o_result.result_kind !== due_result.result_kind)
                    report_mismatch("result_kind", int'(o_result.result_kind),
                                    int'(due_result.result_kind));
                if (o_result.lost_slot !== due_result.lost_slot)
                    report_mismatch("lost_slot", int'(o_result.lost_slot),
                                    int'(due_result.lost_slot));
                if (o_result.acquired !== due_result.acquired)
                    report_mismatch("acquired", int'(o_result.acquired),
                                    int'(due_result.acquired));
                if (o_result.last !== due_result.last)
                    report_mismatch("last", int'(o_result.last), int'(due_result.last));
            end
        end
    end

    // Hand-picked items: line wrap at the top of memory, the line boundary,
    // a masked-off slot, acquires that break all other holders, acquires
    // with no reservation or a different address, overwrite, unused kind.
    task automatic test_directed();
        logic [31:0] line_a;
        line_a = 32'h1234_5680;
        send_item(make_item(KIND_RESERVE, 0, 32'hFFFF_FFC0, 8'h00));
        send_item(make_item(KIND_WRITE, 0, 32'h0000_003F, 8'h01));
        for (int s = 0; s < THREAD_SLOTS; s++)
            send_item(make_item(KIND_RESERVE, s, line_a, 8'h00));
        send_item(make_item(KIND_ACQUIRE, 3, line_a, 8'h00));
        for (int s = 0; s < THREAD_SLOTS; s++)
            send_item(make_item(KIND_RESERVE, s, line_a + 32'(s), 8'h00));
        // Slot 0 sits exactly one line below the written byte and survives.
        send_item(make_item(KIND_WRITE, 5, line_a + 32'd128, 8'hFF));
        send_item(make_item(KIND_WRITE, 2, line_a + 32'd127, 8'h00));
        send_item(make_item(KIND_ACQUIRE, 0, line_a + 32'd1, 8'h00));
        send_item(make_item(KIND_ACQUIRE, 0, line_a, 8'h00));
        send_item(make_item(KIND_RESERVE, 6, 32'h0000_0000, 8'h00));
        send_item(make_item(KIND_RESERVE, 6, 32'hFFFF_FFFF, 8'h00));
        send_item(make_item(KIND_ACQUIRE, 6, 32'hFFFF_FFFF, 8'h00));
        send_item(make_item(KIND_UNUSED, 7, 32'hFFFF_FFFF, 8'hFF));
    endtask

    // Several threads reserve the same line, then some of them try to
    // acquire it; mostly with the address they reserved.
    task automatic test_acquire_contention(input int count);
        int          sent;
        int          slot;
        logic [31:0] base;
        logic [31:0] addr;
        sent = 0;
        while (sent < count) begin
            base = random_base();
            repeat ($urandom_range(2, 8)) begin
                slot = $urandom_range(0, THREAD_SLOTS - 1);
                addr = ($urandom_range(0, 9) < 7) ? base : base + 32'($urandom_range(1, 127));
                send_item(make_item(KIND_RESERVE, slot, addr, 8'($urandom())));
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                slot = $urandom_range(0, THREAD_SLOTS - 1);
                if (resv_valid[slot] && $urandom_range(0, 4) != 0)
                    addr = resv_addr[slot];
                else
                    addr = base + 32'($urandom_range(0, 3));
                send_item(make_item(KIND_ACQUIRE, slot, addr, 8'($urandom())));
                sent++;
            end
        end
    endtask

    // Reservations on a few lines, then snooped writes around them, from
    // just below a line to just past its end, with random change masks.
    task automatic test_snooped_writes(input int count);
        int          sent;
        logic [31:0] base;
        logic [7:0]  mask;
        sent = 0;
        while (sent < count) begin
            base = random_base();
            repeat ($urandom_range(1, 8)) begin
                send_item(make_item(KIND_RESERVE, $urandom_range(0, THREAD_SLOTS - 1),
                                    base + 32'($urandom_range(0, 40)), 8'($urandom())));
                sent++;
            end
            repeat ($urandom_range(1, 4)) begin
                mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
                send_item(make_item(KIND_WRITE, $urandom_range(0, THREAD_SLOTS - 1),
                                    base + 32'($urandom_range(0, 176)) - 32'd16, mask));
                sent++;
            end
        end
    endtask

    // Unstructured traffic: any kind, any slot, addresses either fully
    // random or near a recent reservation.
    task automatic test_random_traffic(input int count);
        logic [1:0]  kind;
        int          slot;
        logic [31:0] addr;
        repeat (count) begin
            kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
            slot = $urandom_range(0, THREAD_SLOTS - 1);
            if ($urandom_range(0, 1) == 0 && resv_valid[slot])
                addr = resv_addr[slot] + 32'($urandom_range(0, 130));
            else
                addr = $urandom();
            send_item(make_item(kind, slot, addr, 8'($urandom())));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int s = 0; s < THREAD_SLOTS; s++) begin
            resv_valid[s] = 1'b0;
            resv_addr[s]  = '0;
        end

        test_directed();
        wait_results_drained();
        test_acquire_contention(140);
        wait_results_drained();
        test_snooped_writes(140);
        test_random_traffic(75);
        wait_results_drained();

        // Closing stretch at full rate with no idle bursts.
        sender_gaps = 1'b0;
        test_snooped_writes(25);
        test_acquire_contention(25);
        wait_results_drained();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
